### src/qts_pkg.sv
package qts_pkg;

    localparam int SPACE_COUNT_BITS = 8;
    localparam int SPACE_REG_BITS   = (SPACE_COUNT_BITS > 8) ? 8 : SPACE_COUNT_BITS;
    localparam logic [SPACE_REG_BITS-1:0] SPACE_LIMIT = {SPACE_REG_BITS{1'b1}};

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_COMMA  = 8'h2c;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_EQUALS = 8'h3d;
    localparam logic [7:0] CHAR_LBRACE = 8'h7b;
    localparam logic [7:0] CHAR_RBRACE = 8'h7d;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;

    typedef struct packed {
        logic [7:0] char_in;
        logic       string_last;
    } qts_in_t;

    typedef struct packed {
        logic [7:0] space_run;
        logic       has_char;
        logic [7:0] char_out;
        logic       token_end;
    } qts_out_t;

    typedef struct packed {
        logic                      in_quotes;
        logic                      token_started;
        logic [SPACE_REG_BITS-1:0] pending_spaces;
    } qts_state_t;

endpackage

### src/quoted_token_splitter.sv
// quoted_token_splitter: splits a byte stream into tokens
// s_ channel: one byte per transfer (char_in) with string_last on the final
//   byte of each string
// m_ channel: zero or one result per byte: withheld space count, optional
//   token character and a token end mark
// cfg channel: writes brace_mode (reset 1); always ready, write only while idle
// path: the byte sits in the input register, then its result loads into
//   the result register
// throughput: one byte per cycle when not stalled by the receiver, set by
//   the single pass of classification logic between input and result registers
// a byte that yields no result is dropped from the input register without
//   waiting on the result register
// receiver stall: the result register holds; the input register fills and
//   then s_ready falls until m_ready returns
// reset (aresetn low, synchronous): both registers empty, quote mode,
//   token state and pending spaces cleared, brace_mode set
module quoted_token_splitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qts_pkg::qts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output qts_pkg::qts_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import qts_pkg::*;

    qts_in_t    in_reg;
    logic       in_valid_reg;
    qts_out_t   out_reg;
    logic       out_valid_reg;
    qts_state_t state_reg;
    logic       brace_mode_reg;

    qts_out_t   result;
    logic       emit;
    qts_state_t state_next;
    logic       advance;
    logic       out_free;

    qts_step u_step (
        .item       (in_reg),
        .state      (state_reg),
        .brace_mode (brace_mode_reg),
        .result     (result),
        .emit       (emit),
        .state_next (state_next)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && (out_free || !emit);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
            brace_mode_reg <= 1'b1;
        end else begin
            if (cfg_valid) begin
                brace_mode_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

endmodule

### src/qts_step.sv
module qts_step (
    input  qts_pkg::qts_in_t    item,
    input  qts_pkg::qts_state_t state,
    input  logic                brace_mode,
    output qts_pkg::qts_out_t   result,
    output logic                emit,
    output qts_pkg::qts_state_t state_next
);
    import qts_pkg::*;

    logic is_quote;
    logic is_delim;

    always_comb begin
        is_quote = (item.char_in == CHAR_QUOTE);
        is_delim = is_quote;
        if (!state.in_quotes) begin
            if (item.char_in == CHAR_COMMA || item.char_in == CHAR_COLON ||
                item.char_in == CHAR_EQUALS) begin
                is_delim = 1'b1;
            end
            if (brace_mode &&
                (item.char_in == CHAR_LBRACE || item.char_in == CHAR_RBRACE)) begin
                is_delim = 1'b1;
            end
        end
    end

    always_comb begin
        result     = '0;
        emit       = 1'b0;
        state_next = state;
        if (is_delim) begin
            if (state.token_started) begin
                result.token_end = 1'b1;
                emit             = 1'b1;
            end
            if (is_quote) begin
                state_next.in_quotes = ~state.in_quotes;
            end
            state_next.token_started  = 1'b0;
            state_next.pending_spaces = '0;
        end else if (item.char_in == CHAR_SPACE) begin
            if (state.token_started && state.pending_spaces != SPACE_LIMIT) begin
                state_next.pending_spaces = state.pending_spaces + 1'b1;
            end
            if (item.string_last && state.token_started) begin
                result.token_end = 1'b1;
                emit             = 1'b1;
            end
        end else if (item.char_in == CHAR_TAB && !state.token_started) begin
            // leading tab dropped
        end else begin
            result.space_run          = 8'(state.pending_spaces);
            result.has_char           = 1'b1;
            result.char_out           = item.char_in;
            result.token_end          = item.string_last;
            emit                      = 1'b1;
            state_next.token_started  = 1'b1;
            state_next.pending_spaces = '0;
        end
        if (item.string_last) begin
            state_next = '0;
        end
    end

endmodule
